FILE: rtl/tea_block_decrypt_assert.svh
`ifndef TEA_BLOCK_DECRYPT_ASSERT_SVH
`define TEA_BLOCK_DECRYPT_ASSERT_SVH

// Checked property, with the check held off while reset is high.
`define TEA_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked property, checked in reset as well.
`define TEA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/tea_pkg.sv
package tea_pkg;

   localparam int WORD_WIDTH          = 32;
   localparam int CSR_INDEX_WIDTH     = 8;
   localparam int DEFAULT_ROUND_COUNT = 32;

   typedef logic [WORD_WIDTH-1:0]      word_type;
   typedef logic [CSR_INDEX_WIDTH-1:0] csr_index_type;

   localparam word_type TEA_DELTA = 32'h9e3779b9;

   localparam csr_index_type KEY_WORD0 = 8'd0;
   localparam csr_index_type KEY_WORD1 = 8'd1;
   localparam csr_index_type KEY_WORD2 = 8'd2;
   localparam csr_index_type KEY_WORD3 = 8'd3;

   typedef struct packed {
      word_type left;
      word_type right;
   } block_type;

   typedef struct packed {
      word_type word0;
      word_type word1;
      word_type word2;
      word_type word3;
   } key_type;

   function automatic word_type mix_word(word_type w, word_type sum, word_type ka,
                                         word_type kb);
      return ((w << 4) + ka) ^ (w + sum) ^ ((w >> 5) + kb);
   endfunction

   // Round sum as a constant: delta times the number of rounds still to undo.
   function automatic word_type round_sum(int unsigned rounds_left);
      logic [2*WORD_WIDTH-1:0] product;
      product = (2*WORD_WIDTH)'(TEA_DELTA) * (2*WORD_WIDTH)'(rounds_left);
      return product[WORD_WIDTH-1:0];
   endfunction

endpackage

FILE: rtl/tea_channels.sv
interface tea_req_if;
   import tea_pkg::*;
   logic     valid;
   logic     ready;
   word_type cipher_left;
   word_type cipher_right;
   modport source (output valid, output cipher_left, output cipher_right, input ready);
   modport sink (input valid, input cipher_left, input cipher_right, output ready);
endinterface

interface tea_rsp_if;
   import tea_pkg::*;
   logic     valid;
   logic     ready;
   word_type plain_left;
   word_type plain_right;
   modport source (output valid, output plain_left, output plain_right, input ready);
   modport sink (input valid, input plain_left, input plain_right, output ready);
endinterface

interface tea_csr_if;
   import tea_pkg::*;
   logic          valid;
   logic          ready;
   csr_index_type index;
   word_type      data;
   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

FILE: rtl/tea_keys.sv
module tea_keys (
   input  logic             clock,
   input  logic             reset,
   tea_csr_if.sink          csr,
   output tea_pkg::key_type key
);
   import tea_pkg::*;

   key_type key_ff;
   key_type key_in;

   assign csr.ready = 1'b1;
   assign key       = key_ff;

   always_comb begin
      key_in = key_ff;
      if (csr.valid) begin
         case (csr.index)
            KEY_WORD0: key_in.word0 = csr.data;
            KEY_WORD1: key_in.word1 = csr.data;
            KEY_WORD2: key_in.word2 = csr.data;
            KEY_WORD3: key_in.word3 = csr.data;
            default:   key_in = key_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff <= '0;
      end else begin
         key_ff <= key_in;
      end
   end

endmodule

FILE: rtl/tea_cell.sv
module tea_cell #(
   parameter bit                UNDO_RIGHT = 1'b1,
   parameter tea_pkg::word_type ROUND_SUM  = '0
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               advance,
   input  logic               in_valid,
   input  tea_pkg::block_type in_block,
   input  tea_pkg::key_type   key,
   output logic               out_valid,
   output tea_pkg::block_type out_block
);
   import tea_pkg::*;

   logic      valid_ff;
   block_type block_ff;
   block_type block_in;

   always_comb begin
      block_in = in_block;
      if (UNDO_RIGHT) begin
         block_in.right = in_block.right
                        - mix_word(in_block.left, ROUND_SUM, key.word2, key.word3);
      end else begin
         block_in.left = in_block.left
                       - mix_word(in_block.right, ROUND_SUM, key.word0, key.word1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         block_ff <= block_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_block = block_ff;

endmodule

FILE: rtl/tea_block_decrypt.sv
// Throughput: one word per cycle while the chain advances; each round is split over two cells, right half then left.
// The whole cell chain holds while a result waits and rsp_chan.ready is low.
// Reset is synchronous: it empties the chain and clears all four key words to zero.
module tea_block_decrypt #(
   parameter int ROUND_COUNT = tea_pkg::DEFAULT_ROUND_COUNT
) (
   input logic      clock,
   input logic      reset,
   tea_req_if.sink  req_chan,
   tea_rsp_if.source rsp_chan,
   tea_csr_if.sink  csr_chan
);
   import tea_pkg::*;

   localparam int NUM_CELLS = 2 * ROUND_COUNT;

   key_type   key;
   logic      advance;
   logic      valid_chain [0:NUM_CELLS];
   block_type block_chain [0:NUM_CELLS];

   tea_keys u_keys (
      .clock (clock),
      .reset (reset),
      .csr   (csr_chan),
      .key   (key)
   );

   assign advance        = !valid_chain[NUM_CELLS] || rsp_chan.ready;
   assign req_chan.ready = advance;
   assign valid_chain[0] = req_chan.valid;
   assign block_chain[0] = {req_chan.cipher_left, req_chan.cipher_right};

   for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
      localparam int RoundIdx = i >> 1;
      tea_cell #(
         .UNDO_RIGHT ((i & 1) == 0),
         .ROUND_SUM  (round_sum(ROUND_COUNT - RoundIdx))
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .in_valid  (valid_chain[i]),
         .in_block  (block_chain[i]),
         .key       (key),
         .out_valid (valid_chain[i+1]),
         .out_block (block_chain[i+1])
      );
   end

   assign rsp_chan.valid       = valid_chain[NUM_CELLS];
   assign rsp_chan.plain_left  = block_chain[NUM_CELLS].left;
   assign rsp_chan.plain_right = block_chain[NUM_CELLS].right;

`include "tea_block_decrypt_assert.svh"

   `TEA_ASSERT(a_stall_blocks_input, clock, reset, (rsp_chan.valid && !rsp_chan.ready) |-> !req_chan.ready, "input taken while the result is stalled")
   `TEA_ASSERT_ALWAYS(a_empty_after_reset, clock, $past(reset) |-> !rsp_chan.valid, "result valid right after reset")
   `TEA_ASSERT(a_key0_write, clock, reset, (csr_chan.valid && csr_chan.ready && csr_chan.index == KEY_WORD0) |=> key.word0 == $past(csr_chan.data), "key word 0 not written")

endmodule

FILE: sim/tea_decrypt_checker.sv
`timescale 1ns / 100ps

module tea_decrypt_checker #(
   parameter int ROUNDS = tea_pkg::DEFAULT_ROUND_COUNT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_ready,
   input  tea_pkg::word_type  cipher_left,
   input  tea_pkg::word_type  cipher_right,
   input  logic               rsp_valid,
   input  logic               rsp_ready,
   input  tea_pkg::word_type  plain_left,
   input  tea_pkg::word_type  plain_right,
   input  logic               csr_valid,
   input  logic               csr_ready,
   input  tea_pkg::csr_index_type csr_index,
   input  tea_pkg::word_type  csr_data,
   output int                 error_count,
   output int                 pending_count,
   output int                 checked_count
);
   import tea_pkg::*;

   key_type   key_copy;
   block_type expected_blocks[$];
   int        errors;
   int        checked;

   function automatic block_type decrypt_block(block_type cipher, key_type key);
      word_type left;
      word_type right;
      word_type sum;
      int       n;
      left  = cipher.left;
      right = cipher.right;
      sum   = '0;
      for (n = 0; n < ROUNDS; n++) begin
         sum = sum + TEA_DELTA;
      end
      for (n = 0; n < ROUNDS; n++) begin
         right = right - (((left << 4) + key.word2) ^ (left + sum) ^ ((left >> 5) + key.word3));
         left  = left - (((right << 4) + key.word0) ^ (right + sum) ^ ((right >> 5) + key.word1));
         sum   = sum - TEA_DELTA;
      end
      decrypt_block.left  = left;
      decrypt_block.right = right;
   endfunction

   initial begin
      key_copy = '0;
      errors   = 0;
      checked  = 0;
   end

   always @(posedge clock) begin
      block_type want;
      block_type cipher;
      if (reset) begin
         key_copy = '0;
         expected_blocks.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_blocks.size() == 0) begin
               $display("%0t: unexpected result word %h %h", $time, plain_left, plain_right);
               errors++;
            end else begin
               want = expected_blocks.pop_front();
               checked++;
               if (plain_left !== want.left) begin
                  $display("%0t: plain_left mismatch, expected %h, got %h",
                           $time, want.left, plain_left);
                  errors++;
               end
               if (plain_right !== want.right) begin
                  $display("%0t: plain_right mismatch, expected %h, got %h",
                           $time, want.right, plain_right);
                  errors++;
               end
            end
         end
         if (req_valid && req_ready) begin
            cipher.left  = cipher_left;
            cipher.right = cipher_right;
            expected_blocks.push_back(decrypt_block(cipher, key_copy));
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               KEY_WORD0: key_copy.word0 = csr_data;
               KEY_WORD1: key_copy.word1 = csr_data;
               KEY_WORD2: key_copy.word2 = csr_data;
               KEY_WORD3: key_copy.word3 = csr_data;
               default: begin
               end
            endcase
         end
      end
      error_count   <= errors;
      pending_count <= expected_blocks.size();
      checked_count <= checked;
   end

endmodule

FILE: sim/tb.sv
`timescale 1ns / 100ps

module tb;
   import tea_pkg::*;

   localparam int            LATENCY      = 2 * DEFAULT_ROUND_COUNT;
   localparam int            PHASE_COUNT  = 9;
   localparam int            PHASE_BLOCKS = 150;
   localparam csr_index_type TOP_INDEX    = '1;
   localparam csr_index_type FIRST_UNUSED = 8'd4;

   logic clock;
   logic reset;
   bit   quiet_mode;
   int   error_count;
   int   pending_count;
   int   checked_count;
   int   blocks_sent;
   int   key_loads;

   tea_req_if req_chan();
   tea_rsp_if rsp_chan();
   tea_csr_if csr_chan();

   tea_block_decrypt i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   tea_decrypt_checker i_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_chan.valid),
      .req_ready     (req_chan.ready),
      .cipher_left   (req_chan.cipher_left),
      .cipher_right  (req_chan.cipher_right),
      .rsp_valid     (rsp_chan.valid),
      .rsp_ready     (rsp_chan.ready),
      .plain_left    (rsp_chan.plain_left),
      .plain_right   (rsp_chan.plain_right),
      .csr_valid     (csr_chan.valid),
      .csr_ready     (csr_chan.ready),
      .csr_index     (csr_chan.index),
      .csr_data      (csr_chan.data),
      .error_count   (error_count),
      .pending_count (pending_count),
      .checked_count (checked_count)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #2000000;
      $display("simulation failed");
      $finish;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (quiet_mode || r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 10);
      return $urandom_range(20, 80);
   endfunction

   initial begin
      int hold;
      hold = 0;
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (reset || quiet_mode) begin
            rsp_chan.ready <= 1'b1;
            hold = 0;
         end else if (hold > 0) begin
            rsp_chan.ready <= 1'b0;
            hold--;
         end else begin
            rsp_chan.ready <= 1'b1;
            if ($urandom_range(0, 3) == 0) hold = pick_gap();
         end
      end
   end

   task automatic send_block(input word_type left, input word_type right);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid        <= 1'b1;
      req_chan.cipher_left  <= left;
      req_chan.cipher_right <= right;
      do @(posedge clock); while (!req_chan.ready);
      blocks_sent++;
   endtask

   function automatic word_type pick_word();
      int r;
      r = $urandom_range(0, 15);
      if (r == 0) return '0;
      if (r == 1) return '1;
      return $urandom;
   endfunction

   task automatic csr_write(input csr_index_type index, input word_type data);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         csr_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      csr_chan.valid <= 1'b1;
      csr_chan.index <= index;
      csr_chan.data  <= data;
      do @(posedge clock); while (!csr_chan.ready);
   endtask

   // Writes to unused indexes must leave the key untouched.
   task automatic load_key(input key_type key, input bit add_stray);
      csr_write(KEY_WORD0, key.word0);
      csr_write(KEY_WORD1, key.word1);
      if (add_stray) begin
         csr_write(TOP_INDEX, $urandom);
         csr_write(csr_index_type'($urandom_range(FIRST_UNUSED, TOP_INDEX)), $urandom);
      end
      csr_write(KEY_WORD2, key.word2);
      csr_write(KEY_WORD3, key.word3);
      csr_chan.valid <= 1'b0;
      key_loads++;
   endtask

   task automatic finish_phase();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   initial begin
      key_type key;
      int      p;
      quiet_mode  = 1'b0;
      blocks_sent = 0;
      key_loads   = 0;
      reset                 <= 1'b1;
      req_chan.valid        <= 1'b0;
      req_chan.cipher_left  <= '0;
      req_chan.cipher_right <= '0;
      csr_chan.valid        <= 1'b0;
      csr_chan.index        <= '0;
      csr_chan.data         <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // The reset key is all zero until the first write.
      send_block('0, '0);
      send_block('1, '1);
      send_block('1, '0);
      send_block('0, '1);
      send_block(32'h80000000, 32'h00000001);
      finish_phase();

      load_key('1, 1'b1);
      send_block('0, '0);
      send_block('1, '1);
      send_block(32'h12345678, 32'h9abcdef0);
      finish_phase();

      load_key(key_type'({32'h00000000, 32'hffffffff, 32'h80000000, 32'h7fffffff}), 1'b1);
      send_block(32'haaaaaaaa, 32'h55555555);
      send_block(32'h55555555, 32'haaaaaaaa);
      send_block(32'h00000001, 32'h80000000);
      finish_phase();

      load_key('0, 1'b0);
      send_block(32'h41ea3a0a, 32'h94baa940);
      send_block(32'h7fffffff, 32'hfffffffe);
      finish_phase();

      for (p = 0; p < PHASE_COUNT; p++) begin
         if (p == 3) key = '1;
         else if (p == 6) key = '0;
         else key = key_type'({$urandom, $urandom, $urandom, $urandom});
         quiet_mode = (p == 4);
         load_key(key, p[0]);
         repeat (PHASE_BLOCKS) send_block(pick_word(), pick_word());
         finish_phase();
      end
      quiet_mode = 1'b0;

      repeat (LATENCY + 8) @(posedge clock);
      $display("Decrypted %0d blocks under %0d key loads, %0d results checked,",
               blocks_sent, key_loads, checked_count);
      $display("with random gaps on the request, result and register channels.");
      if (error_count == 0 && pending_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
